@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpm_pkg
// Types, constants and constant dividers of the converter protection monitor.
// ----------------------------------------------------------------------------
package cpm_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int AC_CHANNELS  = 2;
	localparam int CHANNEL_W    = 2;
	localparam int DATA_W       = 16;
	localparam int DCV_W        = 13;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [6:0]        RST_ENABLE_MASK       = 7'd0;
	localparam logic [DATA_W-1:0] RST_LOW_CURRENT_DELAY = 16'd200;
	localparam logic [DATA_W-1:0] RST_GRID_FAIL_LIMIT   = 16'd50;
	localparam logic [DATA_W-1:0] RST_GRID_LOW_LIMIT    = 16'd340;
	localparam logic [DATA_W-1:0] RST_GRID_HIGH_LIMIT   = 16'd420;
	localparam logic [DCV_W-1:0]  RST_DC_LOW_LIMIT      = 13'd20;
	localparam logic [DCV_W-1:0]  RST_DC_HIGH_LIMIT     = 13'd32;
	localparam logic [DCV_W-1:0]  RST_DC_OVER_LIMIT     = 13'd40;

	// Bit positions in the enable mask.
	localparam int MASK_LOW_CURRENT = 0;
	localparam int MASK_GRID_FAIL   = 1;
	localparam int MASK_GRID_LOW    = 2;
	localparam int MASK_GRID_HIGH   = 3;
	localparam int MASK_DC_LOW      = 4;
	localparam int MASK_DC_HIGH     = 5;
	localparam int MASK_DC_OVER     = 6;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLE_MASK       = 3'd0,
		CFG_LOW_CURRENT_DELAY = 3'd1,
		CFG_GRID_FAIL_LIMIT   = 3'd2,
		CFG_GRID_LOW_LIMIT    = 3'd3,
		CFG_GRID_HIGH_LIMIT   = 3'd4,
		CFG_DC_LOW_LIMIT      = 3'd5,
		CFG_DC_HIGH_LIMIT     = 3'd6,
		CFG_DC_OVER_LIMIT     = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		FUNC_STOPPED = 2'd0,
		FUNC_RUN     = 2'd1,
		FUNC_ACK     = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		FAULT_NONE        = 3'd0,
		FAULT_LOW_CURRENT = 3'd1,
		FAULT_GRID_FAIL   = 3'd2,
		FAULT_GRID_LOW    = 3'd3,
		FAULT_GRID_HIGH   = 3'd4,
		FAULT_DC_LOW      = 3'd5,
		FAULT_DC_HIGH     = 3'd6,
		FAULT_DC_OVER     = 3'd7
	} fault_code_t;

	typedef struct packed {
		logic [6:0]        enable_mask;
		logic [DATA_W-1:0] low_current_delay;
		logic [DATA_W-1:0] grid_fail_limit;
		logic [DATA_W-1:0] grid_low_limit;
		logic [DATA_W-1:0] grid_high_limit;
		logic [DCV_W-1:0]  dc_low_limit;
		logic [DCV_W-1:0]  dc_high_limit;
		logic [DCV_W-1:0]  dc_over_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           func;
		logic [CHANNEL_W-1:0] channel;
		logic [DATA_W-1:0]    volt_a;
		logic [DATA_W-1:0]    volt_b;
		logic [DATA_W-1:0]    volt_c;
		logic [DATA_W-1:0]    cur_a;
		logic [DATA_W-1:0]    cur_b;
		logic [DATA_W-1:0]    cur_c;
		logic [DATA_W-1:0]    freq_raw;
		logic [DATA_W-1:0]    grid_a;
		logic [DATA_W-1:0]    grid_b;
		logic [DATA_W-1:0]    grid_c;
	} item_t;

	typedef struct packed {
		logic [1:0]           func;
		logic [CHANNEL_W-1:0] channel;
		logic [DATA_W-1:0]    cur_a;
		logic [DCV_W-1:0]     volt_a10;
		logic [14:0]          volt_sum;
		logic [DATA_W-1:0]    cur_mean;
		logic [DCV_W-1:0]     freq10;
		logic                 grid_fail;
		logic                 grid_low;
		logic                 grid_high;
	} pre_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] out_channel;
		logic [DATA_W-1:0]    volt_avg;
		logic [DATA_W-1:0]    cur_avg;
		logic [DCV_W-1:0]     freq_avg;
		logic [DATA_W-1:0]    cur_peak;
		logic                 fault_latched;
		logic [2:0]           fault_code;
		logic                 stop_request;
	} res_t;

	// x / 10 for 16-bit x: multiply by ceil(2^19 / 10) and shift.
	function automatic logic [DCV_W-1:0] div10_u16(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(17'd52429);
		return p[31:19];
	endfunction

	// x / 3 for 18-bit x: multiply by ceil(2^19 / 3) and shift.
	function automatic logic [15:0] div3_u18(input logic [17:0] x);
		logic [35:0] p;
		p = 36'(x) * 36'(18'd174763);
		return p[34:19];
	endfunction

	// x / 3 for x up to 19659: multiply by ceil(2^16 / 3) and shift.
	function automatic logic [DCV_W-1:0] div3_u15(input logic [14:0] x);
		logic [29:0] p;
		p = 30'(x) * 30'(15'd21846);
		return p[28:16];
	endfunction

	function automatic logic [15:0] avg16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16:1];
	endfunction

	function automatic logic [DCV_W-1:0] avg13(input logic [DCV_W-1:0] a,
		input logic [DCV_W-1:0] b);
		logic [DCV_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DCV_W:1];
	endfunction

endpackage

@@ rtl/converter_protection_monitor.sv @@
// ----------------------------------------------------------------------------
// converter_protection_monitor
// Protection monitor for AC and DC power converters with running averages.
// ----------------------------------------------------------------------------
// Each input word carries one converter channel's telemetry and the metered
// grid voltages; func selects a stopped sample, a running sample or a fault
// acknowledge. Channels 0 and 1 are AC, higher channels are DC. Every word
// gives exactly one result word with the channel's averages, peak current,
// fault latch, fault code and a stop request pulse for a newly set fault.
// Both channels use valid/ready; the configuration port is a plain write
// port and must only be written while the monitor is idle.
// The path is three registers deep: input register, prescale stage and the
// update stage with its result register, which each word passes in that order.
// One word per cycle is sustained while the receiver does not stall; the
// figure is set by the read-modify-write of the channel state.
// When the receiver stalls, the result is held and words behind it fill the
// empty stages before in_ready falls. Reset clears all channel state, the
// pipeline valids and loads the default limits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module converter_protection_monitor #(
	parameter int NUM_CHANNELS = cpm_pkg::NUM_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cpm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [cpm_pkg::CHANNEL_W-1:0]     channel,
	input  logic [cpm_pkg::DATA_W-1:0]        volt_a,
	input  logic [cpm_pkg::DATA_W-1:0]        volt_b,
	input  logic [cpm_pkg::DATA_W-1:0]        volt_c,
	input  logic [cpm_pkg::DATA_W-1:0]        cur_a,
	input  logic [cpm_pkg::DATA_W-1:0]        cur_b,
	input  logic [cpm_pkg::DATA_W-1:0]        cur_c,
	input  logic [cpm_pkg::DATA_W-1:0]        freq_raw,
	input  logic [cpm_pkg::DATA_W-1:0]        grid_a,
	input  logic [cpm_pkg::DATA_W-1:0]        grid_b,
	input  logic [cpm_pkg::DATA_W-1:0]        grid_c,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cpm_pkg::CHANNEL_W-1:0]     out_channel,
	output logic [cpm_pkg::DATA_W-1:0]        volt_avg,
	output logic [cpm_pkg::DATA_W-1:0]        cur_avg,
	output logic [cpm_pkg::DCV_W-1:0]         freq_avg,
	output logic [cpm_pkg::DATA_W-1:0]        cur_peak,
	output logic                              fault_latched,
	output logic [2:0]                        fault_code,
	output logic                              stop_request
);

	cpm_pkg::cfg_t  cfg;
	cpm_pkg::item_t item_s1;
	cpm_pkg::pre_t  pre_s2;
	cpm_pkg::res_t  res;
	logic           valid_s1;
	logic           valid_s2;
	logic           pre_ready;
	logic           adv;

	assign in_ready = !valid_s1 || pre_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{func: func, channel: channel, volt_a: volt_a, volt_b: volt_b,
				volt_c: volt_c, cur_a: cur_a, cur_b: cur_b, cur_c: cur_c,
				freq_raw: freq_raw, grid_a: grid_a, grid_b: grid_b, grid_c: grid_c};
		end
	end

	cpm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpm_prescale u_prescale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.adv      (adv),
		.ready    (pre_ready),
		.valid_s2 (valid_s2),
		.pre_s2   (pre_s2)
	);

	cpm_update #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.pre_s2    (pre_s2),
		.out_ready (out_ready),
		.adv       (adv),
		.out_valid (out_valid),
		.res       (res)
	);

	assign out_channel   = res.out_channel;
	assign volt_avg      = res.volt_avg;
	assign cur_avg       = res.cur_avg;
	assign freq_avg      = res.freq_avg;
	assign cur_peak      = res.cur_peak;
	assign fault_latched = res.fault_latched;
	assign fault_code    = res.fault_code;
	assign stop_request  = res.stop_request;

	`CPM_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready, "input stalled while the result register is empty")

endmodule

@@ rtl/cpm_cfg.sv @@
// ----------------------------------------------------------------------------
// cpm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cpm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output cpm_pkg::cfg_t                      cfg
);

	cpm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask       <= cpm_pkg::RST_ENABLE_MASK;
			cfg_q.low_current_delay <= cpm_pkg::RST_LOW_CURRENT_DELAY;
			cfg_q.grid_fail_limit   <= cpm_pkg::RST_GRID_FAIL_LIMIT;
			cfg_q.grid_low_limit    <= cpm_pkg::RST_GRID_LOW_LIMIT;
			cfg_q.grid_high_limit   <= cpm_pkg::RST_GRID_HIGH_LIMIT;
			cfg_q.dc_low_limit      <= cpm_pkg::RST_DC_LOW_LIMIT;
			cfg_q.dc_high_limit     <= cpm_pkg::RST_DC_HIGH_LIMIT;
			cfg_q.dc_over_limit     <= cpm_pkg::RST_DC_OVER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				cpm_pkg::CFG_ENABLE_MASK:       cfg_q.enable_mask       <= cfg_data[6:0];
				cpm_pkg::CFG_LOW_CURRENT_DELAY: cfg_q.low_current_delay <= cfg_data;
				cpm_pkg::CFG_GRID_FAIL_LIMIT:   cfg_q.grid_fail_limit   <= cfg_data;
				cpm_pkg::CFG_GRID_LOW_LIMIT:    cfg_q.grid_low_limit    <= cfg_data;
				cpm_pkg::CFG_GRID_HIGH_LIMIT:   cfg_q.grid_high_limit   <= cfg_data;
				cpm_pkg::CFG_DC_LOW_LIMIT:      cfg_q.dc_low_limit      <= cfg_data[12:0];
				cpm_pkg::CFG_DC_HIGH_LIMIT:     cfg_q.dc_high_limit     <= cfg_data[12:0];
				cpm_pkg::CFG_DC_OVER_LIMIT:     cfg_q.dc_over_limit     <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/cpm_prescale.sv @@
// ----------------------------------------------------------------------------
// cpm_prescale
// Second pipeline stage: constant divisions, phase sums and grid limit tests.
// ----------------------------------------------------------------------------
module cpm_prescale (
	input  logic           clk,
	input  logic           arst_n,
	input  cpm_pkg::cfg_t  cfg,
	input  logic           valid_s1,
	input  cpm_pkg::item_t item_s1,
	input  logic           adv,
	output logic           ready,
	output logic           valid_s2,
	output cpm_pkg::pre_t  pre_s2
);

	cpm_pkg::pre_t           pre_d;
	logic [cpm_pkg::DCV_W-1:0] vb10;
	logic [cpm_pkg::DCV_W-1:0] vc10;
	logic [17:0]             cur_sum;
	logic                    valid_q;

	always_comb begin
		pre_d.func     = item_s1.func;
		pre_d.channel  = item_s1.channel;
		pre_d.cur_a    = item_s1.cur_a;
		pre_d.volt_a10 = cpm_pkg::div10_u16(item_s1.volt_a);
		vb10           = cpm_pkg::div10_u16(item_s1.volt_b);
		vc10           = cpm_pkg::div10_u16(item_s1.volt_c);
		pre_d.volt_sum = 15'(pre_d.volt_a10) + 15'(vb10) + 15'(vc10);
		cur_sum        = 18'(item_s1.cur_a) + 18'(item_s1.cur_b) + 18'(item_s1.cur_c);
		pre_d.cur_mean = cpm_pkg::div3_u18(cur_sum);
		pre_d.freq10   = cpm_pkg::div10_u16(item_s1.freq_raw);
		pre_d.grid_fail = (item_s1.grid_a < cfg.grid_fail_limit) ||
			(item_s1.grid_b < cfg.grid_fail_limit) ||
			(item_s1.grid_c < cfg.grid_fail_limit);
		pre_d.grid_low = (item_s1.grid_a < cfg.grid_low_limit) ||
			(item_s1.grid_b < cfg.grid_low_limit) ||
			(item_s1.grid_c < cfg.grid_low_limit);
		pre_d.grid_high = (item_s1.grid_a > cfg.grid_high_limit) ||
			(item_s1.grid_b > cfg.grid_high_limit) ||
			(item_s1.grid_c > cfg.grid_high_limit);
	end

	assign ready = !valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s1) begin
			pre_s2 <= pre_d;
		end
	end

	assign valid_s2 = valid_q;

endmodule

@@ rtl/cpm_update.sv @@
// ----------------------------------------------------------------------------
// cpm_update
// Final stage: per-channel state update, fault checks and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpm_update #(
	parameter int NUM_CHANNELS = cpm_pkg::NUM_CHANNELS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cpm_pkg::cfg_t cfg,
	input  logic          valid_s2,
	input  cpm_pkg::pre_t pre_s2,
	input  logic          out_ready,
	output logic          adv,
	output logic          out_valid,
	output cpm_pkg::res_t res
);

	localparam int CH_W  = $clog2(NUM_CHANNELS);
	localparam int IDX_W = (CH_W > cpm_pkg::CHANNEL_W) ? CH_W : cpm_pkg::CHANNEL_W;

	logic [cpm_pkg::DATA_W-1:0] volt_avg_q   [NUM_CHANNELS];
	logic [cpm_pkg::DATA_W-1:0] cur_avg_q    [NUM_CHANNELS];
	logic [cpm_pkg::DCV_W-1:0]  freq_avg_q   [NUM_CHANNELS];
	logic [cpm_pkg::DATA_W-1:0] cur_peak_q   [NUM_CHANNELS];
	logic [cpm_pkg::DATA_W-1:0] delay_q      [NUM_CHANNELS];
	logic                       flag_q       [NUM_CHANNELS];
	logic [2:0]                 number_q     [NUM_CHANNELS];

	logic [IDX_W-1:0]           ch_ext;
	logic [CH_W-1:0]            idx;
	logic                       in_range;
	logic                       commit;
	logic                       running;
	logic                       ack;
	logic                       is_dc;
	logic                       check;
	logic                       lc_hit;
	logic                       hit;
	logic [2:0]                 code;
	logic [cpm_pkg::DATA_W-1:0] dc_cur;
	logic [cpm_pkg::DATA_W-1:0] delay_old;
	logic [cpm_pkg::DATA_W-1:0] delay_inc;
	logic [cpm_pkg::DCV_W-1:0]  volt_mean;
	logic [cpm_pkg::DATA_W-1:0] volt_n;
	logic [cpm_pkg::DATA_W-1:0] cur_n;
	logic [cpm_pkg::DCV_W-1:0]  freq_n;
	logic [cpm_pkg::DATA_W-1:0] peak_n;
	logic [cpm_pkg::DATA_W-1:0] delay_n;
	logic                       flag_n;
	logic [2:0]                 number_n;
	cpm_pkg::res_t              res_d;
	cpm_pkg::res_t              res_q;
	logic                       out_valid_q;

	assign ch_ext   = IDX_W'(pre_s2.channel);
	assign idx      = ch_ext[CH_W-1:0];
	assign in_range = ({1'b0, ch_ext} < (IDX_W + 1)'(NUM_CHANNELS));
	assign adv      = !out_valid_q || out_ready;
	assign commit   = valid_s2 && adv && in_range;

	always_comb begin
		running   = (pre_s2.func == cpm_pkg::FUNC_RUN);
		ack       = (pre_s2.func == cpm_pkg::FUNC_ACK);
		is_dc     = (pre_s2.channel >= cpm_pkg::CHANNEL_W'(cpm_pkg::AC_CHANNELS));
		volt_mean = cpm_pkg::div3_u15(pre_s2.volt_sum);
		delay_old = delay_q[idx];

		volt_n = volt_avg_q[idx];
		cur_n  = cur_avg_q[idx];
		freq_n = freq_avg_q[idx];
		peak_n = cur_peak_q[idx];
		if (running) begin
			if (is_dc) begin
				volt_n = cpm_pkg::avg16(volt_avg_q[idx], 16'(pre_s2.volt_a10));
				cur_n  = cpm_pkg::avg16(cur_avg_q[idx], pre_s2.cur_a);
				if (pre_s2.cur_a > cur_peak_q[idx]) begin
					peak_n = pre_s2.cur_a;
				end
			end else begin
				volt_n = cpm_pkg::avg16(volt_avg_q[idx], 16'(volt_mean));
				cur_n  = cpm_pkg::avg16(cur_avg_q[idx], pre_s2.cur_mean);
				freq_n = cpm_pkg::avg13(freq_avg_q[idx], pre_s2.freq10);
			end
		end

		check     = running && !flag_q[idx];
		dc_cur    = is_dc ? pre_s2.cur_a : '0;
		delay_inc = (delay_old == '1) ? delay_old : delay_old + 16'd1;
		lc_hit    = cfg.enable_mask[cpm_pkg::MASK_LOW_CURRENT] &&
			(delay_old >= cfg.low_current_delay) && (dc_cur == '0);

		code = cpm_pkg::FAULT_NONE;
		if (lc_hit) begin
			code = cpm_pkg::FAULT_LOW_CURRENT;
		end
		if (cfg.enable_mask[cpm_pkg::MASK_GRID_FAIL] && pre_s2.grid_fail) begin
			code = cpm_pkg::FAULT_GRID_FAIL;
		end
		if (cfg.enable_mask[cpm_pkg::MASK_GRID_LOW] && pre_s2.grid_low) begin
			code = cpm_pkg::FAULT_GRID_LOW;
		end
		if (cfg.enable_mask[cpm_pkg::MASK_GRID_HIGH] && cfg.enable_mask[cpm_pkg::MASK_GRID_LOW] &&
			pre_s2.grid_high) begin
			code = cpm_pkg::FAULT_GRID_HIGH;
		end
		if (is_dc && cfg.enable_mask[cpm_pkg::MASK_DC_LOW] &&
			(pre_s2.volt_a10 < cfg.dc_low_limit)) begin
			code = cpm_pkg::FAULT_DC_LOW;
		end
		if (is_dc && cfg.enable_mask[cpm_pkg::MASK_DC_HIGH] &&
			(pre_s2.volt_a10 > cfg.dc_high_limit)) begin
			code = cpm_pkg::FAULT_DC_HIGH;
		end
		if (is_dc && cfg.enable_mask[cpm_pkg::MASK_DC_OVER] &&
			(pre_s2.volt_a10 > cfg.dc_over_limit)) begin
			code = cpm_pkg::FAULT_DC_OVER;
		end
		hit = check && (code != cpm_pkg::FAULT_NONE);

		if (!check) begin
			volt_n  = '0;
			cur_n   = '0;
			delay_n = '0;
		end else if (!cfg.enable_mask[cpm_pkg::MASK_LOW_CURRENT]) begin
			delay_n = delay_old;
		end else if (lc_hit) begin
			delay_n = cfg.low_current_delay;
		end else begin
			delay_n = delay_inc;
		end

		flag_n   = flag_q[idx];
		number_n = number_q[idx];
		if (hit) begin
			flag_n   = 1'b1;
			number_n = code;
		end else if (ack) begin
			flag_n   = 1'b0;
			number_n = cpm_pkg::FAULT_NONE;
		end

		res_d             = '0;
		res_d.out_channel = pre_s2.channel;
		if (in_range) begin
			res_d.volt_avg      = volt_n;
			res_d.cur_avg       = cur_n;
			res_d.freq_avg      = freq_n;
			res_d.cur_peak      = peak_n;
			res_d.fault_latched = flag_n;
			res_d.fault_code    = number_n;
			res_d.stop_request  = hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				volt_avg_q[i] <= '0;
				cur_avg_q[i]  <= '0;
				freq_avg_q[i] <= '0;
				cur_peak_q[i] <= '0;
				delay_q[i]    <= '0;
				flag_q[i]     <= 1'b0;
				number_q[i]   <= cpm_pkg::FAULT_NONE;
			end
		end else if (commit) begin
			volt_avg_q[idx] <= volt_n;
			cur_avg_q[idx]  <= cur_n;
			freq_avg_q[idx] <= freq_n;
			cur_peak_q[idx] <= peak_n;
			delay_q[idx]    <= delay_n;
			flag_q[idx]     <= flag_n;
			number_q[idx]   <= number_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`CPM_ASSERT_IMPL(a_stop_has_code, out_valid_q && res_q.stop_request, res_q.fault_latched && (res_q.fault_code != cpm_pkg::FAULT_NONE), "stop request without a latched fault code")
	`CPM_ASSERT_IMPL(a_code_needs_latch, out_valid_q && !res_q.fault_latched, res_q.fault_code == cpm_pkg::FAULT_NONE, "fault code present without a latched fault")
	`CPM_ASSERT_NEXT(a_ack_clears_latch, commit && ack, !flag_q[$past(idx)], "acknowledge did not clear the fault latch")

endmodule

@@ tb/cpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_checker
// Watches both channels of the converter protection monitor, keeps its own
// copy of the channel state and the limit registers, predicts the status
// word of every accepted input word and compares each result word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cpm_checker
	import cpm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [1:0]             func,
	input  logic [CHANNEL_W-1:0]   channel,
	input  logic [DATA_W-1:0]      volt_a,
	input  logic [DATA_W-1:0]      volt_b,
	input  logic [DATA_W-1:0]      volt_c,
	input  logic [DATA_W-1:0]      cur_a,
	input  logic [DATA_W-1:0]      cur_b,
	input  logic [DATA_W-1:0]      cur_c,
	input  logic [DATA_W-1:0]      freq_raw,
	input  logic [DATA_W-1:0]      grid_a,
	input  logic [DATA_W-1:0]      grid_b,
	input  logic [DATA_W-1:0]      grid_c,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [CHANNEL_W-1:0]   out_channel,
	input  logic [DATA_W-1:0]      volt_avg,
	input  logic [DATA_W-1:0]      cur_avg,
	input  logic [DCV_W-1:0]       freq_avg,
	input  logic [DATA_W-1:0]      cur_peak,
	input  logic                   fault_latched,
	input  logic [2:0]             fault_code,
	input  logic                   stop_request,
	output int                     mismatch_count,
	output int                     status_outstanding,
	output int                     checked_count,
	output int                     stop_count
);

	cfg_t        limits;
	logic [15:0] volt_mean    [NUM_CHANNELS];
	logic [15:0] cur_mean     [NUM_CHANNELS];
	logic [12:0] freq_mean    [NUM_CHANNELS];
	logic [15:0] peak_cur     [NUM_CHANNELS];
	logic [12:0] dc_volt      [NUM_CHANNELS];
	logic [15:0] dc_amps      [NUM_CHANNELS];
	logic [15:0] delay_cnt    [NUM_CHANNELS];
	logic        latched      [NUM_CHANNELS];
	fault_code_t latched_code [NUM_CHANNELS];

	res_t   pending_status [$];
	res_t   want;
	item_t  word_in;
	res_t   seen;

	assign word_in = {func, channel, volt_a, volt_b, volt_c, cur_a, cur_b, cur_c, freq_raw,
		grid_a, grid_b, grid_c};
	assign seen = {out_channel, volt_avg, cur_avg, freq_avg, cur_peak, fault_latched,
		fault_code, stop_request};

	function automatic res_t predict_channel_status(input item_t w);
		res_t        r;
		int          ch;
		logic        running;
		logic        dc;
		logic        hit;
		fault_code_t new_code;
		int unsigned vsum;
		int unsigned isum;
		logic [15:0] old_delay;
		logic [15:0] grid [3];
		r = '0;
		r.out_channel = w.channel;
		ch = int'(w.channel);
		if (ch >= NUM_CHANNELS)
			return r;
		running = (w.func == FUNC_RUN);
		dc = (ch >= AC_CHANNELS);
		hit = 1'b0;
		new_code = FAULT_NONE;
		grid[0] = w.grid_a;
		grid[1] = w.grid_b;
		grid[2] = w.grid_c;

		if (w.func == FUNC_ACK) begin
			latched[ch] = 1'b0;
			latched_code[ch] = FAULT_NONE;
		end

		if (running) begin
			if (!dc) begin
				vsum = int'(w.volt_a) / 10 + int'(w.volt_b) / 10 + int'(w.volt_c) / 10;
				isum = int'(w.cur_a) + int'(w.cur_b) + int'(w.cur_c);
				volt_mean[ch] = 16'((int'(volt_mean[ch]) + vsum / 3) / 2);
				cur_mean[ch] = 16'((int'(cur_mean[ch]) + isum / 3) / 2);
				freq_mean[ch] = 13'((int'(freq_mean[ch]) + int'(w.freq_raw) / 10) / 2);
			end else begin
				dc_volt[ch] = 13'(int'(w.volt_a) / 10);
				dc_amps[ch] = w.cur_a;
				cur_mean[ch] = 16'((int'(cur_mean[ch]) + int'(w.cur_a)) / 2);
				volt_mean[ch] = 16'((int'(volt_mean[ch]) + int'(dc_volt[ch])) / 2);
				if (w.cur_a > peak_cur[ch])
					peak_cur[ch] = w.cur_a;
			end
		end

		if (running && !latched[ch]) begin
			if (limits.enable_mask[MASK_LOW_CURRENT]) begin
				old_delay = delay_cnt[ch];
				if (old_delay != 16'hFFFF)
					delay_cnt[ch] = old_delay + 16'd1;
				if (old_delay >= limits.low_current_delay && dc_amps[ch] == 16'd0) begin
					hit = 1'b1;
					new_code = FAULT_LOW_CURRENT;
					delay_cnt[ch] = limits.low_current_delay;
				end
			end
			for (int j = 0; j < 3; j++) begin
				if (limits.enable_mask[MASK_GRID_FAIL] && grid[j] < limits.grid_fail_limit) begin
					hit = 1'b1;
					new_code = FAULT_GRID_FAIL;
				end
			end
			for (int j = 0; j < 3; j++) begin
				if (limits.enable_mask[MASK_GRID_LOW] && grid[j] < limits.grid_low_limit) begin
					hit = 1'b1;
					new_code = FAULT_GRID_LOW;
				end
			end
			if (limits.enable_mask[MASK_GRID_HIGH] && limits.enable_mask[MASK_GRID_LOW]) begin
				for (int j = 0; j < 3; j++) begin
					if (grid[j] > limits.grid_high_limit) begin
						hit = 1'b1;
						new_code = FAULT_GRID_HIGH;
					end
				end
			end
			if (dc) begin
				if (limits.enable_mask[MASK_DC_LOW] && dc_volt[ch] < limits.dc_low_limit) begin
					hit = 1'b1;
					new_code = FAULT_DC_LOW;
				end
				if (limits.enable_mask[MASK_DC_HIGH] && dc_volt[ch] > limits.dc_high_limit) begin
					hit = 1'b1;
					new_code = FAULT_DC_HIGH;
				end
				if (limits.enable_mask[MASK_DC_OVER] && dc_volt[ch] > limits.dc_over_limit) begin
					hit = 1'b1;
					new_code = FAULT_DC_OVER;
				end
			end
		end else begin
			cur_mean[ch] = 16'd0;
			volt_mean[ch] = 16'd0;
			delay_cnt[ch] = 16'd0;
		end

		if (hit) begin
			latched[ch] = 1'b1;
			latched_code[ch] = new_code;
		end

		r.volt_avg = volt_mean[ch];
		r.cur_avg = cur_mean[ch];
		r.freq_avg = freq_mean[ch];
		r.cur_peak = peak_cur[ch];
		r.fault_latched = latched[ch];
		r.fault_code = latched_code[ch];
		r.stop_request = hit;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits.enable_mask = RST_ENABLE_MASK;
			limits.low_current_delay = RST_LOW_CURRENT_DELAY;
			limits.grid_fail_limit = RST_GRID_FAIL_LIMIT;
			limits.grid_low_limit = RST_GRID_LOW_LIMIT;
			limits.grid_high_limit = RST_GRID_HIGH_LIMIT;
			limits.dc_low_limit = RST_DC_LOW_LIMIT;
			limits.dc_high_limit = RST_DC_HIGH_LIMIT;
			limits.dc_over_limit = RST_DC_OVER_LIMIT;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				volt_mean[i] = '0;
				cur_mean[i] = '0;
				freq_mean[i] = '0;
				peak_cur[i] = '0;
				dc_volt[i] = '0;
				dc_amps[i] = '0;
				delay_cnt[i] = '0;
				latched[i] = 1'b0;
				latched_code[i] = FAULT_NONE;
			end
			pending_status.delete();
			mismatch_count = 0;
			status_outstanding = 0;
			checked_count = 0;
			stop_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE_MASK:       limits.enable_mask = cfg_data[6:0];
					CFG_LOW_CURRENT_DELAY: limits.low_current_delay = cfg_data;
					CFG_GRID_FAIL_LIMIT:   limits.grid_fail_limit = cfg_data;
					CFG_GRID_LOW_LIMIT:    limits.grid_low_limit = cfg_data;
					CFG_GRID_HIGH_LIMIT:   limits.grid_high_limit = cfg_data;
					CFG_DC_LOW_LIMIT:      limits.dc_low_limit = cfg_data[DCV_W-1:0];
					CFG_DC_HIGH_LIMIT:     limits.dc_high_limit = cfg_data[DCV_W-1:0];
					CFG_DC_OVER_LIMIT:     limits.dc_over_limit = cfg_data[DCV_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_status.push_back(predict_channel_status(word_in));
			if (out_valid && out_ready) begin
				if (pending_status.size() == 0) begin
					$error("Result word for channel %0d arrived with nothing expected",
						out_channel);
					mismatch_count++;
				end else begin
					want = pending_status.pop_front();
					check_field("out_channel", want.out_channel, seen.out_channel);
					check_field("volt_avg", want.volt_avg, seen.volt_avg);
					check_field("cur_avg", want.cur_avg, seen.cur_avg);
					check_field("freq_avg", want.freq_avg, seen.freq_avg);
					check_field("cur_peak", want.cur_peak, seen.cur_peak);
					check_field("fault_latched", want.fault_latched, seen.fault_latched);
					check_field("fault_code", want.fault_code, seen.fault_code);
					check_field("stop_request", want.stop_request, seen.stop_request);
					checked_count++;
					if (seen.stop_request)
						stop_count++;
				end
			end
			status_outstanding = pending_status.size();
		end
	end

endmodule

@@ tb/tb_converter_protection_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_converter_protection_monitor
// Drives the converter protection monitor with a directed set of telemetry
// words, a long low-current delay soak and random words over many limit
// settings, with random stalls on both channels, and reports the verdict of
// the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_converter_protection_monitor;
	import cpm_pkg::*;

	localparam logic [1:0]  FUNC_UNDEFINED = 2'd3;
	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int          RESULT_LATENCY = 3;
	localparam int          RANDOM_PHASES  = 13;
	localparam int          PHASE_WORDS    = 100;
	localparam int          SOAK_WORDS     = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	item_t                  drive_word = '0;
	logic [1:0]             func;
	logic [CHANNEL_W-1:0]   channel;
	logic [DATA_W-1:0]      volt_a;
	logic [DATA_W-1:0]      volt_b;
	logic [DATA_W-1:0]      volt_c;
	logic [DATA_W-1:0]      cur_a;
	logic [DATA_W-1:0]      cur_b;
	logic [DATA_W-1:0]      cur_c;
	logic [DATA_W-1:0]      freq_raw;
	logic [DATA_W-1:0]      grid_a;
	logic [DATA_W-1:0]      grid_b;
	logic [DATA_W-1:0]      grid_c;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CHANNEL_W-1:0]   out_channel;
	logic [DATA_W-1:0]      volt_avg;
	logic [DATA_W-1:0]      cur_avg;
	logic [DCV_W-1:0]       freq_avg;
	logic [DATA_W-1:0]      cur_peak;
	logic                   fault_latched;
	logic [2:0]             fault_code;
	logic                   stop_request;

	int          mismatch_count;
	int          status_outstanding;
	int          checked_count;
	int          stop_count;
	logic        idle_on = 1'b0;
	int          stall_left = 0;
	int          words_sent = 0;
	int          settings_used = 0;
	int unsigned cycle_count = 0;
	cfg_t        cur_cfg;

	assign {func, channel, volt_a, volt_b, volt_c, cur_a, cur_b, cur_c, freq_raw,
		grid_a, grid_b, grid_c} = drive_word;

	converter_protection_monitor DUT (.*);

	cpm_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("converter_protection_monitor verification failed");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input item_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		drive_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (status_outstanding != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(CFG_ENABLE_MASK, 16'(c.enable_mask));
		write_reg(CFG_LOW_CURRENT_DELAY, c.low_current_delay);
		write_reg(CFG_GRID_FAIL_LIMIT, c.grid_fail_limit);
		write_reg(CFG_GRID_LOW_LIMIT, c.grid_low_limit);
		write_reg(CFG_GRID_HIGH_LIMIT, c.grid_high_limit);
		write_reg(CFG_DC_LOW_LIMIT, 16'(c.dc_low_limit));
		write_reg(CFG_DC_HIGH_LIMIT, 16'(c.dc_high_limit));
		write_reg(CFG_DC_OVER_LIMIT, 16'(c.dc_over_limit));
		cfg_we <= 1'b0;
		cur_cfg = c;
		settings_used++;
	endtask

	function automatic cfg_t default_config();
		cfg_t c;
		c.enable_mask = RST_ENABLE_MASK;
		c.low_current_delay = RST_LOW_CURRENT_DELAY;
		c.grid_fail_limit = RST_GRID_FAIL_LIMIT;
		c.grid_low_limit = RST_GRID_LOW_LIMIT;
		c.grid_high_limit = RST_GRID_HIGH_LIMIT;
		c.dc_low_limit = RST_DC_LOW_LIMIT;
		c.dc_high_limit = RST_DC_HIGH_LIMIT;
		c.dc_over_limit = RST_DC_OVER_LIMIT;
		return c;
	endfunction

	function automatic cfg_t random_config(input int kind);
		cfg_t c;
		if (kind == 0) begin
			c = '0;
			c.enable_mask = 7'h7F;
		end else if (kind == 1) begin
			c = '1;
			c.dc_low_limit = 13'd6553;
			c.dc_high_limit = 13'd6553;
			c.dc_over_limit = 13'd6553;
		end else begin
			c.enable_mask = 7'($urandom_range(0, 127));
			c.low_current_delay = ($urandom_range(0, 3) == 0) ?
				16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 12));
			c.grid_fail_limit = 16'($urandom_range(20, 80));
			c.grid_low_limit = 16'($urandom_range(300, 360));
			c.grid_high_limit = 16'($urandom_range(400, 450));
			c.dc_low_limit = 13'($urandom_range(10, 25));
			c.dc_high_limit = 13'($urandom_range(26, 40));
			c.dc_over_limit = 13'($urandom_range(30, 50));
		end
		return c;
	endfunction

	function automatic logic [15:0] pick_level(input int unsigned lo, input int unsigned hi,
		input int unsigned wild);
		int unsigned a;
		int unsigned b;
		if ($urandom_range(0, wild - 1) == 0)
			return 16'($urandom_range(0, 65535));
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		if (b > 65535)
			b = 65535;
		if (a > b)
			a = b;
		return 16'($urandom_range(b, a));
	endfunction

	function automatic logic [15:0] pick_current();
		if ($urandom_range(0, 7) == 0)
			return 16'd0;
		return pick_level(1, 2000, 4);
	endfunction

	function automatic item_t nominal_word(input logic [1:0] fn, input logic [1:0] ch);
		item_t w;
		w.func = fn;
		w.channel = ch;
		w.volt_a = 16'd300;
		w.volt_b = 16'd300;
		w.volt_c = 16'd300;
		w.cur_a = 16'd100;
		w.cur_b = 16'd100;
		w.cur_c = 16'd100;
		w.freq_raw = 16'd500;
		w.grid_a = 16'd380;
		w.grid_b = 16'd380;
		w.grid_c = 16'd380;
		return w;
	endfunction

	function automatic item_t random_word();
		item_t       w;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			w.func = FUNC_RUN;
		else if (pick < 16)
			w.func = FUNC_ACK;
		else if (pick < 18)
			w.func = FUNC_STOPPED;
		else
			w.func = FUNC_UNDEFINED;
		w.channel = 2'($urandom_range(0, 3));
		if (w.channel < AC_CHANNELS) begin
			w.volt_a = pick_level(3000, 4500, 4);
			w.volt_b = pick_level(3000, 4500, 4);
			w.volt_c = pick_level(3000, 4500, 4);
		end else begin
			w.volt_a = pick_level(int'(cur_cfg.dc_low_limit) * 10,
				int'(cur_cfg.dc_over_limit) * 10 + 100, 4);
			w.volt_b = 16'($urandom_range(0, 65535));
			w.volt_c = 16'($urandom_range(0, 65535));
		end
		w.cur_a = pick_current();
		w.cur_b = pick_current();
		w.cur_c = pick_current();
		w.freq_raw = pick_level(490, 510, 4);
		w.grid_a = pick_level(cur_cfg.grid_low_limit, cur_cfg.grid_high_limit, 12);
		w.grid_b = pick_level(cur_cfg.grid_low_limit, cur_cfg.grid_high_limit, 12);
		w.grid_c = pick_level(cur_cfg.grid_low_limit, cur_cfg.grid_high_limit, 12);
		return w;
	endfunction

	task automatic run_directed();
		item_t w;
		cfg_t  c;
		// With every check off: field extremes and every function code.
		w = '1;
		w.func = FUNC_RUN;
		w.channel = 2'd0;
		send_word(w);
		w.channel = 2'd2;
		send_word(w);
		w = '0;
		w.func = FUNC_RUN;
		w.channel = 2'd1;
		send_word(w);
		w.channel = 2'd3;
		send_word(w);
		w = '1;
		w.func = FUNC_STOPPED;
		w.channel = 2'd0;
		send_word(w);
		w.func = FUNC_UNDEFINED;
		w.channel = 2'd2;
		send_word(w);
		w.func = FUNC_ACK;
		w.channel = 2'd1;
		send_word(w);
		settle();

		// Every check on with no low-current delay, so later codes overwrite earlier ones.
		c = default_config();
		c.enable_mask = 7'h7F;
		c.low_current_delay = 16'd0;
		apply_config(c);
		send_word(nominal_word(FUNC_RUN, 2'd0));
		send_word(nominal_word(FUNC_RUN, 2'd0));
		send_word(nominal_word(FUNC_ACK, 2'd0));
		send_word(nominal_word(FUNC_RUN, 2'd2));
		w = nominal_word(FUNC_RUN, 2'd2);
		w.volt_a = 16'd500;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd2));
		w.volt_a = 16'd350;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd2));
		w.volt_a = 16'd100;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd2));
		w = nominal_word(FUNC_RUN, 2'd3);
		w.grid_a = 16'd10;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd3));
		w = nominal_word(FUNC_RUN, 2'd1);
		w.grid_c = 16'd500;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd1));
		settle();

		// The grid high check stays silent unless the grid low check is enabled too.
		c.enable_mask = 7'((1 << MASK_GRID_FAIL) | (1 << MASK_GRID_HIGH));
		apply_config(c);
		w = nominal_word(FUNC_RUN, 2'd1);
		w.grid_a = 16'd500;
		w.grid_b = 16'd500;
		w.grid_c = 16'd500;
		send_word(w);
		w.grid_b = 16'd10;
		send_word(w);
		send_word(nominal_word(FUNC_ACK, 2'd1));
		settle();
	endtask

	// The delay counter runs on through a long stretch of live words past the
	// delay, so a zero current afterwards trips the low-current check.
	task automatic run_saturation_soak();
		item_t w;
		cfg_t  c;
		c = default_config();
		c.enable_mask = 7'(1 << MASK_LOW_CURRENT);
		c.low_current_delay = 16'd250;
		apply_config(c);
		idle_on = 1'b0;
		send_word(nominal_word(FUNC_ACK, 2'd2));
		for (int i = 0; i < SOAK_WORDS; i++) begin
			w = random_word();
			w.func = FUNC_RUN;
			w.channel = 2'd2;
			w.cur_a = 16'($urandom_range(1, 65535));
			send_word(w);
		end
		w = nominal_word(FUNC_RUN, 2'd2);
		w.cur_a = 16'd0;
		send_word(w);
		send_word(w);
		settle();
	endtask

	initial begin
		cur_cfg = default_config();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_on = 1'b1;
		run_directed();
		run_saturation_soak();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			apply_config(random_config(p));
			idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 4) != 0);
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word(random_word());
		end
		settle();
		$display("Checked %0d result words against %0d input words; %0d raised a stop request.",
			checked_count, words_sent, stop_count);
		$display("Covered %0d limit settings, the extremes among them, and a long delay soak.",
			settings_used);
		if (mismatch_count == 0)
			$display("converter_protection_monitor verification clean");
		else
			$display("converter_protection_monitor verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cpm_pkg.sv
rtl/cpm_cfg.sv
rtl/cpm_prescale.sv
rtl/cpm_update.sv
rtl/converter_protection_monitor.sv
tb/cpm_checker.sv
tb/tb_converter_protection_monitor.sv
